// ===== hdl/ppeu_pkg.sv =====
package ppeu_pkg;

   localparam int PARTICLE_SLOTS = 1024;

   localparam logic [15:0] GRAVITY_RESET = 16'd40141;
   localparam logic [13:0] INIT_LIFE_RESET = 14'd6144;
   localparam logic [10:0] ALIVE_MAX = 11'd2047;

   localparam logic signed [19:0] POS_MAX = 20'sd524287;
   localparam logic signed [19:0] POS_MIN = -20'sd524288;
   localparam logic signed [17:0] VEL_MAX = 18'sd131071;
   localparam logic signed [17:0] VEL_MIN = -18'sd131072;

   typedef enum logic [1:0] {
      OP_SPAWN = 2'd0,
      OP_TICK  = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic {
      CFG_GRAVITY   = 1'b0,
      CFG_INIT_LIFE = 1'b1
   } cfg_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_SPAWN_WR,
      ST_TICK,
      ST_DRAIN,
      ST_READ,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
      logic signed [19:0] pos_z;
      logic signed [17:0] vel_x;
      logic signed [17:0] vel_y;
      logic signed [17:0] vel_z;
      logic [13:0]        life;
      logic               active;
   } slot_type;

   typedef struct packed {
      logic latch;
      logic rd_en;
      logic rd_tick;
      logic rd_user;
      logic wr_clear;
      logic wr_spawn;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic hit;
      logic rd_pending;
      logic tick_busy;
   } status_type;

endpackage

// ===== hdl/ppeu_ram.sv =====
module ppeu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

// ===== hdl/ppeu_ctrl.sv =====
module ppeu_ctrl #(
   parameter int PARTICLE_SLOTS = ppeu_pkg::PARTICLE_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_opcode,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output ppeu_pkg::cmd_type                 cmd,
   input  ppeu_pkg::status_type              status,
   input  logic [$clog2(PARTICLE_SLOTS)-1:0] hit_addr,
   output logic [$clog2(PARTICLE_SLOTS)-1:0] rd_addr,
   output logic [$clog2(PARTICLE_SLOTS)-1:0] wr_addr
);

   localparam int AW = $clog2(PARTICLE_SLOTS);
   localparam logic [AW:0] SLOTS = (AW+1)'(PARTICLE_SLOTS);
   localparam logic [AW:0] LAST = (AW+1)'(PARTICLE_SLOTS - 1);

   ppeu_pkg::state_type state_ff, state_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic [AW-1:0] start_ff, start_in;
   logic [AW-1:0] slot_ff, slot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [AW:0]   sum_w, wrap_w;

   assign rsp_valid = rsp_valid_ff;

   // Search address runs from the start slot and wraps past the last slot.
   assign sum_w = {1'b0, start_ff} + cnt_ff;
   assign wrap_w = (sum_w >= SLOTS) ? sum_w - SLOTS : sum_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ppeu_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         start_ff     <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         start_ff     <= start_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      start_in     = start_ff;
      slot_in      = slot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      rd_addr      = cnt_ff[AW-1:0];
      wr_addr      = cnt_ff[AW-1:0];
      req_ready    = 1'b0;
      case (state_ff)
         ppeu_pkg::ST_CLEAR: begin
            cmd.wr_clear = 1'b1;
            if (cnt_ff == LAST) begin
               cnt_in   = '0;
               state_in = ppeu_pkg::ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ppeu_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               cnt_in    = '0;
               case (req_opcode)
                  ppeu_pkg::OP_SPAWN: state_in = ppeu_pkg::ST_SEARCH;
                  ppeu_pkg::OP_TICK:  state_in = ppeu_pkg::ST_TICK;
                  ppeu_pkg::OP_READ:  state_in = ppeu_pkg::ST_READ;
                  default:            state_in = ppeu_pkg::ST_IDLE;
               endcase
            end
         end
         ppeu_pkg::ST_SEARCH: begin
            if (status.hit) begin
               slot_in  = hit_addr;
               start_in = hit_addr;
               state_in = ppeu_pkg::ST_SPAWN_WR;
            end else if (cnt_ff == SLOTS) begin
               // With the pool full slot 0 is taken and the start is kept.
               if (!status.rd_pending) begin
                  slot_in  = '0;
                  state_in = ppeu_pkg::ST_SPAWN_WR;
               end
            end else begin
               cmd.rd_en = 1'b1;
               rd_addr   = wrap_w[AW-1:0];
               cnt_in    = cnt_ff + 1'b1;
            end
         end
         ppeu_pkg::ST_SPAWN_WR: begin
            cmd.wr_spawn = 1'b1;
            wr_addr      = slot_ff;
            state_in     = ppeu_pkg::ST_FINISH;
         end
         ppeu_pkg::ST_TICK: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_tick = 1'b1;
            if (cnt_ff == LAST) begin
               state_in = ppeu_pkg::ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ppeu_pkg::ST_DRAIN: begin
            if (!status.tick_busy) begin
               state_in = ppeu_pkg::ST_FINISH;
            end
         end
         ppeu_pkg::ST_READ: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_user = 1'b1;
            state_in    = ppeu_pkg::ST_FINISH;
         end
         ppeu_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ppeu_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ppeu_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/ppeu_dp.sv =====
module ppeu_dp #(
   parameter int PARTICLE_SLOTS = ppeu_pkg::PARTICLE_SLOTS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic                              csr_index,
   input  logic [15:0]                       csr_wdata,
   input  logic [1:0]                        req_opcode,
   input  logic signed [19:0]                req_origin_x,
   input  logic signed [19:0]                req_origin_y,
   input  logic signed [19:0]                req_origin_z,
   input  logic signed [17:0]                req_start_vel_x,
   input  logic signed [17:0]                req_start_vel_y,
   input  logic signed [17:0]                req_start_vel_z,
   input  logic [11:0]                       req_delta_time,
   input  logic [9:0]                        req_read_slot,
   output logic [9:0]                        rsp_slot_index,
   output logic [10:0]                       rsp_alive_count,
   output logic signed [19:0]                rsp_out_pos_x,
   output logic signed [19:0]                rsp_out_pos_y,
   output logic signed [19:0]                rsp_out_pos_z,
   output logic                              rsp_out_active,
   output logic [13:0]                       rsp_out_life,
   input  ppeu_pkg::cmd_type                 cmd,
   output ppeu_pkg::status_type              status,
   output logic [$clog2(PARTICLE_SLOTS)-1:0] hit_addr,
   input  logic [$clog2(PARTICLE_SLOTS)-1:0] rd_addr,
   input  logic [$clog2(PARTICLE_SLOTS)-1:0] wr_addr
);

   localparam int AW = $clog2(PARTICLE_SLOTS);
   localparam int XW = (AW > 10) ? AW : 10;
   localparam int SW = $bits(ppeu_pkg::slot_type);

   logic [15:0]        gravity_ff;
   logic [13:0]        init_life_ff;
   logic [1:0]         op_ff;
   logic signed [19:0] org_x_ff, org_y_ff, org_z_ff;
   logic signed [17:0] vel_x_ff, vel_y_ff, vel_z_ff;
   logic [11:0]        dt_ff;
   logic [15:0]        gstep_ff;
   logic [9:0]         rslot_ff;
   logic [AW-1:0]      raddr_user_ff;
   logic               in_range_ff;
   logic [AW-1:0]      spawn_slot_ff;
   logic [10:0]        alive_ff;

   logic [27:0]   gprod;
   logic [XW-1:0] rs_ext, spawn_ext;

   logic               s1_valid_ff, s1_tick_ff;
   logic [AW-1:0]      s1_addr_ff;
   logic               s2_valid_ff;
   logic [AW-1:0]      s2_addr_ff;
   ppeu_pkg::slot_type s2_slot_ff;
   logic signed [18:0] dx_ff, dy_ff, dz_ff;

   logic [AW-1:0]      ram_raddr, ram_waddr;
   logic               ram_we;
   logic [SW-1:0]      ram_rdata;
   ppeu_pkg::slot_type q, spawn_word, upd_word, wr_word;
   logic signed [30:0] prod_x, prod_y, prod_z;
   logic signed [20:0] sum_x, sum_y, sum_z;
   logic signed [18:0] vdiff;
   logic [13:0]        dt14;

   assign q = ram_rdata;

   assign gprod = gravity_ff * req_delta_time;
   assign rs_ext = XW'(req_read_slot);
   assign spawn_ext = XW'(spawn_slot_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff   <= ppeu_pkg::GRAVITY_RESET;
         init_life_ff <= ppeu_pkg::INIT_LIFE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            ppeu_pkg::CFG_GRAVITY:   gravity_ff <= csr_wdata;
            ppeu_pkg::CFG_INIT_LIFE: init_life_ff <= csr_wdata[13:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff         <= req_opcode;
         org_x_ff      <= req_origin_x;
         org_y_ff      <= req_origin_y;
         org_z_ff      <= req_origin_z;
         vel_x_ff      <= req_start_vel_x;
         vel_y_ff      <= req_start_vel_y;
         vel_z_ff      <= req_start_vel_z;
         dt_ff         <= req_delta_time;
         gstep_ff      <= gprod[27:12];
         rslot_ff      <= req_read_slot;
         raddr_user_ff <= rs_ext[AW-1:0];
         in_range_ff   <= ({1'b0, rs_ext} < (XW+1)'(PARTICLE_SLOTS));
      end
      if (cmd.wr_spawn) begin
         spawn_slot_ff <= wr_addr;
      end
   end

   // Slot memory: read address from the controller or the read item.
   assign ram_raddr = cmd.rd_user ? raddr_user_ff : rd_addr;
   assign ram_we    = cmd.wr_clear || cmd.wr_spawn || s2_valid_ff;
   assign ram_waddr = s2_valid_ff ? s2_addr_ff : wr_addr;

   always_comb begin
      spawn_word.pos_x  = org_x_ff;
      spawn_word.pos_y  = org_y_ff;
      spawn_word.pos_z  = org_z_ff;
      spawn_word.vel_x  = vel_x_ff;
      spawn_word.vel_y  = vel_y_ff;
      spawn_word.vel_z  = vel_z_ff;
      spawn_word.life   = init_life_ff;
      spawn_word.active = 1'b1;
      if (s2_valid_ff) begin
         wr_word = upd_word;
      end else if (cmd.wr_spawn) begin
         wr_word = spawn_word;
      end else begin
         wr_word = '0;
      end
   end

   ppeu_ram #(
      .WIDTH (SW),
      .DEPTH (PARTICLE_SLOTS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_word),
      .re    (cmd.rd_en),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_tick_ff  <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.rd_en;
         s1_tick_ff  <= cmd.rd_en && cmd.rd_tick;
         s2_valid_ff <= s1_tick_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_addr_ff <= ram_raddr;
   end

   assign status.rd_pending = s1_valid_ff;
   assign status.hit        = s1_valid_ff && !s1_tick_ff && (!q.active || q.life == '0);
   assign status.tick_busy  = s1_tick_ff || s2_valid_ff;
   assign hit_addr          = s1_addr_ff;

   // Tick stage one: velocity times dt; the top bits give the floored Q12 step.
   assign prod_x = q.vel_x * $signed({1'b0, dt_ff});
   assign prod_y = q.vel_y * $signed({1'b0, dt_ff});
   assign prod_z = q.vel_z * $signed({1'b0, dt_ff});

   always_ff @(posedge clock) begin
      s2_addr_ff <= s1_addr_ff;
      s2_slot_ff <= q;
      dx_ff      <= prod_x[30:12];
      dy_ff      <= prod_y[30:12];
      dz_ff      <= prod_z[30:12];
   end

   // Tick stage two: saturating adds, life countdown and write back.
   assign dt14  = {2'b00, dt_ff};
   assign sum_x = {s2_slot_ff.pos_x[19], s2_slot_ff.pos_x} + {{2{dx_ff[18]}}, dx_ff};
   assign sum_y = {s2_slot_ff.pos_y[19], s2_slot_ff.pos_y} + {{2{dy_ff[18]}}, dy_ff};
   assign sum_z = {s2_slot_ff.pos_z[19], s2_slot_ff.pos_z} + {{2{dz_ff[18]}}, dz_ff};
   assign vdiff = {s2_slot_ff.vel_y[17], s2_slot_ff.vel_y} - $signed({3'b000, gstep_ff});

   always_comb begin
      upd_word = s2_slot_ff;
      if (s2_slot_ff.life != '0) begin
         upd_word.life = (s2_slot_ff.life > dt14) ? s2_slot_ff.life - dt14 : '0;
         if (sum_x[20] != sum_x[19]) begin
            upd_word.pos_x = sum_x[20] ? ppeu_pkg::POS_MIN : ppeu_pkg::POS_MAX;
         end else begin
            upd_word.pos_x = sum_x[19:0];
         end
         if (sum_y[20] != sum_y[19]) begin
            upd_word.pos_y = sum_y[20] ? ppeu_pkg::POS_MIN : ppeu_pkg::POS_MAX;
         end else begin
            upd_word.pos_y = sum_y[19:0];
         end
         if (sum_z[20] != sum_z[19]) begin
            upd_word.pos_z = sum_z[20] ? ppeu_pkg::POS_MIN : ppeu_pkg::POS_MAX;
         end else begin
            upd_word.pos_z = sum_z[19:0];
         end
         if (vdiff[18] != vdiff[17]) begin
            upd_word.vel_y = vdiff[18] ? ppeu_pkg::VEL_MIN : ppeu_pkg::VEL_MAX;
         end else begin
            upd_word.vel_y = vdiff[17:0];
         end
      end else begin
         upd_word.active = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         alive_ff <= '0;
      end else if (s2_valid_ff && upd_word.active && alive_ff != ppeu_pkg::ALIVE_MAX) begin
         alive_ff <= alive_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_slot_index  <= '0;
         rsp_alive_count <= '0;
         rsp_out_pos_x   <= '0;
         rsp_out_pos_y   <= '0;
         rsp_out_pos_z   <= '0;
         rsp_out_active  <= 1'b0;
         rsp_out_life    <= '0;
         case (op_ff)
            ppeu_pkg::OP_SPAWN: begin
               rsp_slot_index <= spawn_ext[9:0];
            end
            ppeu_pkg::OP_TICK: begin
               rsp_alive_count <= alive_ff;
            end
            ppeu_pkg::OP_READ: begin
               rsp_slot_index <= rslot_ff;
               if (in_range_ff) begin
                  rsp_out_pos_x  <= q.pos_x;
                  rsp_out_pos_y  <= q.pos_y;
                  rsp_out_pos_z  <= q.pos_z;
                  rsp_out_active <= q.active;
                  rsp_out_life   <= q.life;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// ===== hdl/particle_pool_euler_update.sv =====
// Pool of PARTICLE_SLOTS particle slots in one single-port-write slot memory,
// run by a controller and an update datapath. After reset the block zeroes
// every slot of the memory and takes no item meanwhile (configuration
// writes still go through). Items are handled one at a time: a spawn's
// free-slot search checks one slot per cycle through the memory read port,
// and a tick updates one slot per cycle through a two-stage
// read-modify-write pipeline. A finished item waits in the output register
// while the next item is taken.
module particle_pool_euler_update #(
   parameter int PARTICLE_SLOTS = ppeu_pkg::PARTICLE_SLOTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_opcode,
   input  logic signed [19:0] req_origin_x,
   input  logic signed [19:0] req_origin_y,
   input  logic signed [19:0] req_origin_z,
   input  logic signed [17:0] req_start_vel_x,
   input  logic signed [17:0] req_start_vel_y,
   input  logic signed [17:0] req_start_vel_z,
   input  logic [11:0]        req_delta_time,
   input  logic [9:0]         req_read_slot,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [9:0]         rsp_slot_index,
   output logic [10:0]        rsp_alive_count,
   output logic signed [19:0] rsp_out_pos_x,
   output logic signed [19:0] rsp_out_pos_y,
   output logic signed [19:0] rsp_out_pos_z,
   output logic               rsp_out_active,
   output logic [13:0]        rsp_out_life
);

   localparam int AW = $clog2(PARTICLE_SLOTS);

   ppeu_pkg::cmd_type    cmd;
   ppeu_pkg::status_type status;
   logic [AW-1:0]        hit_addr, rd_addr, wr_addr;

   assign csr_ready = 1'b1;

   ppeu_ctrl #(
      .PARTICLE_SLOTS (PARTICLE_SLOTS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .status     (status),
      .hit_addr   (hit_addr),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr)
   );

   ppeu_dp #(
      .PARTICLE_SLOTS (PARTICLE_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_opcode      (req_opcode),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_origin_z    (req_origin_z),
      .req_start_vel_x (req_start_vel_x),
      .req_start_vel_y (req_start_vel_y),
      .req_start_vel_z (req_start_vel_z),
      .req_delta_time  (req_delta_time),
      .req_read_slot   (req_read_slot),
      .rsp_slot_index  (rsp_slot_index),
      .rsp_alive_count (rsp_alive_count),
      .rsp_out_pos_x   (rsp_out_pos_x),
      .rsp_out_pos_y   (rsp_out_pos_y),
      .rsp_out_pos_z   (rsp_out_pos_z),
      .rsp_out_active  (rsp_out_active),
      .rsp_out_life    (rsp_out_life),
      .cmd             (cmd),
      .status          (status),
      .hit_addr        (hit_addr),
      .rd_addr         (rd_addr),
      .wr_addr         (wr_addr)
   );

endmodule

// ===== hdl/ppeu_checker.sv =====
module ppeu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [9:0]  rsp_slot_index,
   input logic [10:0] rsp_alive_count,
   input logic        rsp_out_active
);

   a_reset_no_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_slot_index) && $stable(rsp_alive_count))
      else $error("stalled result changed");

   a_tick_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_alive_count != 11'd0 |-> rsp_slot_index == 10'd0 && !rsp_out_active)
      else $error("tick result carries slot fields");

   a_read_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_active |-> rsp_alive_count == 11'd0)
      else $error("read result carries a live count");

endmodule

bind particle_pool_euler_update ppeu_checker u_ppeu_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_slot_index  (rsp_slot_index),
   .rsp_alive_count (rsp_alive_count),
   .rsp_out_active  (rsp_out_active)
);

// ===== sim/particle_pool_euler_update_test.sv =====
module particle_pool_euler_update_test;

   localparam int NSLOT = ppeu_pkg::PARTICLE_SLOTS;
   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE_CYCLES = NSLOT + 100;
   localparam int RANDOM_ITEMS = 540;

   typedef struct {
      ppeu_pkg::op_type   op;
      logic signed [19:0] ox, oy, oz;
      logic signed [17:0] vx, vy, vz;
      logic [11:0]        dt;
      logic [9:0]         rs;
   } pool_cmd_type;

   typedef struct {
      logic [9:0]         slot;
      logic [10:0]        alive;
      logic signed [19:0] px, py, pz;
      logic               act;
      logic [13:0]        life;
   } pool_rsp_type;

   typedef struct {
      pool_cmd_type cmd;
      bit           known;
      pool_rsp_type rsp;
   } script_row_type;

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic               csr_index = 0;
   logic [15:0]        csr_wdata = 0;
   logic               req_valid = 0;
   logic               req_ready;
   logic [1:0]         req_opcode = 0;
   logic signed [19:0] req_origin_x = 0, req_origin_y = 0, req_origin_z = 0;
   logic signed [17:0] req_start_vel_x = 0, req_start_vel_y = 0, req_start_vel_z = 0;
   logic [11:0]        req_delta_time = 0;
   logic [9:0]         req_read_slot = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [9:0]         rsp_slot_index;
   logic [10:0]        rsp_alive_count;
   logic signed [19:0] rsp_out_pos_x, rsp_out_pos_y, rsp_out_pos_z;
   logic               rsp_out_active;
   logic [13:0]        rsp_out_life;

   particle_pool_euler_update u_top (.*);

   // Shadow copy of the pool.
   int          pos_x [NSLOT], pos_y [NSLOT], pos_z [NSLOT];
   int          vel_x [NSLOT], vel_y [NSLOT], vel_z [NSLOT];
   int unsigned life_q [NSLOT];
   bit          live_flag [NSLOT];
   int unsigned next_search;
   logic [15:0] gravity_q;
   logic [13:0] spawn_life;

   pool_rsp_type pending_results [$];
   int           mismatches = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           quiet_cycles = 0;
   bit           progress = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int clamp(longint v, longint lo, longint hi);
      if (v < lo) return int'(lo);
      if (v > hi) return int'(hi);
      return int'(v);
   endfunction

   function automatic bit slot_free(int i);
      return !live_flag[i] || life_q[i] == 0;
   endfunction

   // Applies one item to the shadow pool; returns 1 when it yields a result.
   function automatic bit apply_pool_item(pool_cmd_type c, output pool_rsp_type r);
      int          s;
      int unsigned alive;
      longint      g_step;
      longint      dt;
      r = '{default: '0};
      case (c.op)
         ppeu_pkg::OP_SPAWN: begin
            s = -1;
            for (int i = next_search; i < NSLOT && s < 0; i++)
               if (slot_free(i)) s = i;
            for (int i = 0; i < next_search && s < 0; i++)
               if (slot_free(i)) s = i;
            if (s < 0) s = 0;
            else next_search = s;
            pos_x[s] = c.ox; pos_y[s] = c.oy; pos_z[s] = c.oz;
            vel_x[s] = c.vx; vel_y[s] = c.vy; vel_z[s] = c.vz;
            life_q[s] = spawn_life;
            live_flag[s] = 1;
            r.slot = s[9:0];
            return 1;
         end
         ppeu_pkg::OP_TICK: begin
            dt = c.dt;
            g_step = (longint'(gravity_q) * dt) >>> 12;
            alive = 0;
            for (int i = 0; i < NSLOT; i++) begin
               if (life_q[i] > 0) begin
                  life_q[i] = life_q[i] > dt ? life_q[i] - int'(dt) : 0;
                  // The position step uses the velocity from before gravity.
                  pos_x[i] = clamp(pos_x[i] + ((longint'(vel_x[i]) * dt) >>> 12),
                                   ppeu_pkg::POS_MIN, ppeu_pkg::POS_MAX);
                  pos_y[i] = clamp(pos_y[i] + ((longint'(vel_y[i]) * dt) >>> 12),
                                   ppeu_pkg::POS_MIN, ppeu_pkg::POS_MAX);
                  pos_z[i] = clamp(pos_z[i] + ((longint'(vel_z[i]) * dt) >>> 12),
                                   ppeu_pkg::POS_MIN, ppeu_pkg::POS_MAX);
                  vel_y[i] = clamp(longint'(vel_y[i]) - g_step,
                                   ppeu_pkg::VEL_MIN, ppeu_pkg::VEL_MAX);
               end else begin
                  live_flag[i] = 0;
               end
               if (live_flag[i]) alive++;
            end
            r.alive = alive > ppeu_pkg::ALIVE_MAX ? ppeu_pkg::ALIVE_MAX : alive[10:0];
            return 1;
         end
         ppeu_pkg::OP_READ: begin
            s = int'(c.rs);
            r.slot = c.rs;
            r.px = pos_x[s][19:0];
            r.py = pos_y[s][19:0];
            r.pz = pos_z[s][19:0];
            r.act = live_flag[s];
            r.life = life_q[s][13:0];
            return 1;
         end
         default: return 0;
      endcase
   endfunction

   function automatic script_row_type row(ppeu_pkg::op_type op, int ox, int oy, int oz,
                                          int vx, int vy, int vz, int dt, int rs,
                                          bit known, int slot, int alive);
      row.cmd = '{op, 20'(ox), 20'(oy), 20'(oz), 18'(vx), 18'(vy), 18'(vz), 12'(dt),
                  10'(rs)};
      row.known = known;
      row.rsp = '{default: '0};
      row.rsp.slot = 10'(slot);
      row.rsp.alive = 11'(alive);
   endfunction

   task automatic send_item(pool_cmd_type c, bit known, pool_rsp_type typed);
      pool_rsp_type r;
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_opcode <= c.op;
      req_origin_x <= c.ox; req_origin_y <= c.oy; req_origin_z <= c.oz;
      req_start_vel_x <= c.vx; req_start_vel_y <= c.vy; req_start_vel_z <= c.vz;
      req_delta_time <= c.dt;
      req_read_slot <= c.rs;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      if (apply_pool_item(c, r))
         pending_results.push_back(known ? typed : r);
   endtask

   task automatic write_reg(ppeu_pkg::cfg_index_type idx, logic [15:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      if (idx == ppeu_pkg::CFG_GRAVITY) gravity_q = data;
      else spawn_life = data[13:0];
   endtask

   task automatic wait_idle();
      req_valid <= 0;
      while (pending_results.size() > 0) @(posedge clock);
      // A trailing unused opcode yields no result; give the block time to finish.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic pool_cmd_type random_item(int tick_pct);
      pool_cmd_type c;
      int           pick;
      pick = $urandom_range(99);
      if (pick < tick_pct) c.op = ppeu_pkg::OP_TICK;
      else if (pick < tick_pct + 3) c.op = ppeu_pkg::OP_NONE;
      else if (pick < 60) c.op = ppeu_pkg::OP_SPAWN;
      else c.op = ppeu_pkg::OP_READ;
      c.ox = 20'($urandom); c.oy = 20'($urandom); c.oz = 20'($urandom);
      c.vx = 18'($urandom); c.vy = 18'($urandom); c.vz = 18'($urandom);
      c.dt = 12'($urandom);
      c.rs = 10'($urandom);
      return c;
   endfunction

   // Response checker and ready generator.
   always @(posedge clock) begin
      pool_rsp_type e;
      if (rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item: slot %0d", rsp_slot_index);
         end else begin
            e = pending_results.pop_front();
            if (e.slot !== rsp_slot_index || e.alive !== rsp_alive_count ||
                e.px !== rsp_out_pos_x || e.py !== rsp_out_pos_y ||
                e.pz !== rsp_out_pos_z || e.act !== rsp_out_active ||
                e.life !== rsp_out_life) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp slot %0d alive %0d pos %0d %0d %0d act %0d life %0d, got slot %0d alive %0d pos %0d %0d %0d act %0d life %0d",
                           e.slot, e.alive, e.px, e.py, e.pz, e.act, e.life,
                           rsp_slot_index, rsp_alive_count, rsp_out_pos_x,
                           rsp_out_pos_y, rsp_out_pos_z, rsp_out_active, rsp_out_life);
            end
         end
      end
      rsp_ready <= reset ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      script_row_type script [$];
      pool_cmd_type   c;
      pool_rsp_type   none_rsp;
      none_rsp = '{default: '0};
      for (int i = 0; i < NSLOT; i++) begin
         pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
         vel_x[i] = 0; vel_y[i] = 0; vel_z[i] = 0;
         life_q[i] = 0; live_flag[i] = 0;
      end
      next_search = 0;
      gravity_q = ppeu_pkg::GRAVITY_RESET;
      spawn_life = ppeu_pkg::INIT_LIFE_RESET;

      repeat (7) @(posedge clock);
      reset <= 0;

      // Directed part, run with the reset register values.
      script.push_back(row(ppeu_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0));
      script.push_back(row(ppeu_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1023, 1, 1023, 0));
      script.push_back(row(ppeu_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 4095, 0, 1, 0, 0));
      script.push_back(row(ppeu_pkg::OP_SPAWN, ppeu_pkg::POS_MAX, ppeu_pkg::POS_MAX,
                           ppeu_pkg::POS_MAX, ppeu_pkg::VEL_MAX, ppeu_pkg::VEL_MAX,
                           ppeu_pkg::VEL_MAX, 0, 0, 1, 0, 0));
      script.push_back(row(ppeu_pkg::OP_SPAWN, ppeu_pkg::POS_MIN, ppeu_pkg::POS_MIN,
                           ppeu_pkg::POS_MIN, ppeu_pkg::VEL_MIN, ppeu_pkg::VEL_MIN,
                           ppeu_pkg::VEL_MIN, 4095, 1023, 1, 1, 0));
      script.push_back(row(ppeu_pkg::OP_SPAWN, 0, 0, 0, 0, 0, 0, 0, 0, 1, 2, 0));
      script.push_back(row(ppeu_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 3));
      script.push_back(row(ppeu_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 4095, 0, 0, 0, 0));
      script.push_back(row(ppeu_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      script.push_back(row(ppeu_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
      script.push_back(row(ppeu_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 2, 0, 0, 0));
      script.push_back(row(ppeu_pkg::OP_NONE, -1, -1, -1, -1, -1, -1, 4095, 1023, 0, 0, 0));
      script.push_back(row(ppeu_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 4095, 0, 0, 0, 0));
      script.push_back(row(ppeu_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Life is now zero everywhere, so this tick clears every active flag.
      script.push_back(row(ppeu_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0));
      script.push_back(row(ppeu_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0));
      script.push_back(row(ppeu_pkg::OP_SPAWN, 12345, -54321, 7, -4096, 4096, 1, 0, 0, 0,
                           0, 0));
      script.push_back(row(ppeu_pkg::OP_SPAWN, -1, 1, -2, 2, -3, 3, 0, 0, 0, 0, 0));
      script.push_back(row(ppeu_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 2048, 0, 0, 0, 0));
      script.push_back(row(ppeu_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 2, 0, 0, 0));
      script.push_back(row(ppeu_pkg::OP_READ, 0, 0, 0, 0, 0, 0, 0, 3, 0, 0, 0));
      foreach (script[i]) send_item(script[i].cmd, script[i].known, script[i].rsp);

      // Random phases, each under its own register setting and idle pattern.
      for (int phase = 0; phase < 3; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_reg(ppeu_pkg::CFG_GRAVITY, 16'hFFFF);
               write_reg(ppeu_pkg::CFG_INIT_LIFE, 16'h3FFF);
               send_idle_pct = 31; recv_idle_pct = 87;
            end
            1: begin
               write_reg(ppeu_pkg::CFG_GRAVITY, 16'h0000);
               write_reg(ppeu_pkg::CFG_INIT_LIFE, 16'h0000);
               send_idle_pct = 87; recv_idle_pct = 31;
            end
            default: begin
               write_reg(ppeu_pkg::CFG_GRAVITY, 16'($urandom));
               write_reg(ppeu_pkg::CFG_INIT_LIFE, 16'($urandom_range(16383, 1)));
               send_idle_pct = 0; recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            c = random_item(7);
            send_item(c, 0, none_rsp);
         end
      end

      // Reads near both ends of the pool, then long ticks.
      for (int n = 0; n < 8; n++) begin
         c = random_item(0);
         c.op = ppeu_pkg::OP_READ;
         c.rs = 10'(n < 4 ? n : NSLOT - n);
         send_item(c, 0, none_rsp);
      end
      for (int n = 0; n < 6; n++) begin
         c = random_item(0);
         c.op = ppeu_pkg::OP_TICK;
         c.dt = 12'd4095;
         send_item(c, 0, none_rsp);
      end

      req_valid <= 0;
      while (pending_results.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
